@@ rtl/lesf_pkg.sv @@
// Package for the largest empty square finder: widths, register indexes, types and helpers.
package lesf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 11;
  localparam int SCORE_W = 11;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBSTACLE   = 2'd0,
    CFG_ROW_LENGTH = 2'd1,
    CFG_ROW_COUNT  = 2'd2
  } cfg_idx_t;

  // Best square found so far in the current grid.
  typedef struct packed {
    logic [SCORE_W-1:0] size;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } best_t;

  // Saturates a length register into 1 .. hi.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] hi);
    logic [LEN_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = LEN_W'(1);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

@@ rtl/lesf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lesf_cell.sv @@
// Score of one grid cell and update of the best square.
module lesf_cell import lesf_pkg::*; (
  input  logic [CHAR_W-1:0]  cell_char,
  input  logic [CHAR_W-1:0]  obstacle_char,
  input  logic [SCORE_W-1:0] up,
  input  logic [SCORE_W-1:0] left,
  input  logic [SCORE_W-1:0] diag,
  input  logic [COL_W-1:0]   col,
  input  logic [ROW_W-1:0]   row,
  input  best_t              best,
  output logic [SCORE_W-1:0] score,
  output best_t              best_nxt
);

  logic [SCORE_W-1:0] min_lu;
  logic [SCORE_W-1:0] min_all;
  logic [SCORE_W-1:0] col_ext;
  logic [SCORE_W-1:0] row_ext;

  always_comb begin
    min_lu  = (diag < left) ? diag : left;
    min_all = (up < min_lu) ? up : min_lu;
    score   = (cell_char == obstacle_char) ? '0 : min_all + SCORE_W'(1);
  end

  // The top-left corner sits score-1 cells up and to the left.
  always_comb begin
    col_ext  = SCORE_W'(col) + SCORE_W'(1) - score;
    row_ext  = SCORE_W'(row) + SCORE_W'(1) - score;
    best_nxt = best;
    if (score > best.size) begin
      best_nxt.size = score;
      best_nxt.col  = col_ext[COL_W-1:0];
      best_nxt.row  = row_ext[ROW_W-1:0];
    end
  end

endmodule

@@ rtl/largest_empty_square_finder_top.sv @@
// Top level of the largest empty square finder: position tracking, line buffer and result register.
//
//  channel  direction  handshake           payload
//  in       request    in_valid/in_stall   in_cell_char
//  out      result     out_valid/out_stall out_square_size, out_square_col, out_square_row
//  cfg      write      cfg_we              cfg_index, cfg_data
//
// One cell is accepted per cycle while the input does not stall; the line buffer read issued at
// acceptance and the score stage after it set this rate.
// After a grid's last cell is accepted, its result passes the score stage register, then the output register.
// Input stalls only while a grid's last cell waits for a full output register.
// Reset is synchronous and active low; line buffer contents are not cleared.
module largest_empty_square_finder_top import lesf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CHAR_W-1:0]    in_cell_char,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SCORE_W-1:0]   out_square_size,
  output logic [COL_W-1:0]     out_square_col,
  output logic [ROW_W-1:0]     out_square_row
);

  logic [CHAR_W-1:0] obstacle_r;
  logic [LEN_W-1:0]  row_length_r;
  logic [LEN_W-1:0]  row_count_r;

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;

  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic              s1_grid_end_r;
  logic              fwd_r;

  logic [SCORE_W-1:0] left_score_r;
  logic [SCORE_W-1:0] diag_score_r;
  best_t              best_r;

  logic               out_valid_r;
  best_t              out_r;

  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   rows;
  logic               in_accept;
  logic               pos_row_end;
  logic               pos_grid_end;
  logic               out_free;
  logic               s1_fire;
  logic [SCORE_W-1:0] ram_rdata;
  logic [SCORE_W-1:0] up;
  logic [SCORE_W-1:0] left;
  logic [SCORE_W-1:0] diag;
  logic [SCORE_W-1:0] score;
  best_t              best_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_r   <= CHAR_W'(111);
      row_length_r <= LEN_W'(1);
      row_count_r  <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OBSTACLE:   obstacle_r   <= cfg_data[CHAR_W-1:0];
        CFG_ROW_LENGTH: row_length_r <= cfg_data[LEN_W-1:0];
        CFG_ROW_COUNT:  row_count_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len  = clamp_len(row_length_r, LEN_W'(MAX_COLS));
  assign rows = clamp_len(row_count_r, LEN_W'(MAX_ROWS));

  // Handshake control.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (!s1_grid_end_r || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  assign pos_row_end  = (LEN_W'(col_r) + LEN_W'(1)) >= len;
  assign pos_grid_end = pos_row_end && ((LEN_W'(row_r) + LEN_W'(1)) >= rows);

  // Position of the next cell to be accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      if (pos_grid_end) begin
        col_r <= '0;
        row_r <= '0;
      end else if (pos_row_end) begin
        col_r <= '0;
        row_r <= row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // With one cell per row the read hits the column the score stage writes now,
  // so the score just written is taken from the left register instead.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char_r     <= in_cell_char;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_grid_end_r <= pos_grid_end;
      fwd_r         <= s1_fire && (s1_col_r == col_r);
    end
  end

  lesf_ram #(
    .WIDTH(SCORE_W),
    .DEPTH(MAX_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata (score),
    .re    (in_accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    up   = '0;
    if (s1_row_r != '0) begin
      up = fwd_r ? left_score_r : ram_rdata;
    end
    left = (s1_col_r == '0) ? '0 : left_score_r;
    diag = (s1_col_r == '0 || s1_row_r == '0) ? '0 : diag_score_r;
  end

  lesf_cell u_cell (
    .cell_char     (s1_char_r),
    .obstacle_char (obstacle_r),
    .up            (up),
    .left          (left),
    .diag          (diag),
    .col           (s1_col_r),
    .row           (s1_row_r),
    .best          (best_r),
    .score         (score),
    .best_nxt      (best_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_score_r <= '0;
      diag_score_r <= '0;
      best_r       <= '0;
    end else if (s1_fire) begin
      left_score_r <= s1_grid_end_r ? '0 : score;
      diag_score_r <= s1_grid_end_r ? '0 : up;
      best_r       <= s1_grid_end_r ? '0 : best_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_grid_end_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_grid_end_r) begin
      out_r <= best_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_square_size = out_r.size;
  assign out_square_col  = out_r.col;
  assign out_square_row  = out_r.row;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty score stage");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_grid_end_r) |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");

  a_grid_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && pos_grid_end) |=> (col_r == '0 && row_r == '0))
    else $error("position not cleared after the last cell of a grid");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_grid_end_r))
    else $error("result raised without a finished grid");

  a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_grid_end_r) |=> (best_r == '0))
    else $error("best square not cleared after a grid");

endmodule

@@ test/largest_empty_square_finder_checker.sv @@
// Checker for the largest empty square finder: predicts each grid's result and compares it.
module largest_empty_square_finder_checker import lesf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CHAR_W-1:0]    in_cell_char,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SCORE_W-1:0]   out_square_size,
  input  logic [COL_W-1:0]     out_square_col,
  input  logic [ROW_W-1:0]     out_square_row,
  output int                   failures,
  output int                   pending_results
);

  logic [CHAR_W-1:0]  obstacle_q;
  logic [LEN_W-1:0]   row_length_q;
  logic [LEN_W-1:0]   row_count_q;
  logic [SCORE_W-1:0] upper_scores [MAX_COLS];
  logic [SCORE_W-1:0] left_q;
  logic [SCORE_W-1:0] diag_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  best_t              best_q;
  best_t              expected_squares [$];
  int                 err_count = 0;

  assign failures = err_count;

  always @(posedge clk) begin : predict
    int                 len_eff;
    int                 rows_eff;
    logic [SCORE_W-1:0] up;
    logic [SCORE_W-1:0] lft;
    logic [SCORE_W-1:0] dg;
    logic [SCORE_W-1:0] low;
    logic [SCORE_W-1:0] score;
    best_t              want;
    if (!rst_n) begin
      obstacle_q   = 8'd111;
      row_length_q = LEN_W'(1);
      row_count_q  = LEN_W'(1);
      for (int i = 0; i < MAX_COLS; i++) begin
        upper_scores[i] = '0;
      end
      left_q = '0;
      diag_q = '0;
      col_q  = '0;
      row_q  = '0;
      best_q = '0;
      expected_squares.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OBSTACLE:   obstacle_q   = cfg_data[CHAR_W-1:0];
          CFG_ROW_LENGTH: row_length_q = cfg_data[LEN_W-1:0];
          CFG_ROW_COUNT:  row_count_q  = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (expected_squares.size() == 0) begin
          $display("%0t: unexpected result size %0d col %0d row %0d", $time,
                   out_square_size, out_square_col, out_square_row);
          err_count++;
        end else begin
          want = expected_squares.pop_front();
          if (out_square_size !== want.size) begin
            $display("%0t: square_size expected %0d, got %0d", $time, want.size,
                     out_square_size);
            err_count++;
          end
          if (out_square_col !== want.col) begin
            $display("%0t: square_col expected %0d, got %0d", $time, want.col,
                     out_square_col);
            err_count++;
          end
          if (out_square_row !== want.row) begin
            $display("%0t: square_row expected %0d, got %0d", $time, want.row,
                     out_square_row);
            err_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        // Lengths outside the legal range are saturated when they are used.
        len_eff  = (row_length_q == 0) ? 1 :
                   (row_length_q > MAX_COLS) ? MAX_COLS : int'(row_length_q);
        rows_eff = (row_count_q == 0) ? 1 :
                   (row_count_q > MAX_ROWS) ? MAX_ROWS : int'(row_count_q);

        up  = (row_q != 0) ? upper_scores[col_q] : '0;
        lft = (col_q != 0) ? left_q : '0;
        dg  = (col_q != 0 && row_q != 0) ? diag_q : '0;

        if (in_cell_char == obstacle_q) begin
          score = '0;
        end else begin
          low = lft;
          if (dg < low) low = dg;
          if (up < low) low = up;
          score = low + SCORE_W'(1);
        end

        upper_scores[col_q] = score;
        diag_q = up;
        left_q = score;

        // Only a strictly larger square replaces the one already found.
        if (score > best_q.size) begin
          best_q.size = score;
          best_q.col  = COL_W'(int'(col_q) + 1 - int'(score));
          best_q.row  = ROW_W'(int'(row_q) + 1 - int'(score));
        end

        if (int'(col_q) + 1 >= len_eff) begin
          if (int'(row_q) + 1 >= rows_eff) begin
            expected_squares.push_back(best_q);
            left_q = '0;
            diag_q = '0;
            col_q  = '0;
            row_q  = '0;
            best_q = '0;
          end else begin
            col_q = '0;
            row_q = row_q + ROW_W'(1);
          end
        end else begin
          col_q = col_q + COL_W'(1);
        end
      end
    end
    pending_results <= expected_squares.size();
  end

endmodule

@@ test/largest_empty_square_finder_top_test.sv @@
// Testbench top for the largest empty square finder: clock, reset, stimulus and verdict.
module largest_empty_square_finder_top_test import lesf_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 20;
  localparam int RANDOM_CELLS   = 600;
  localparam int MIN_GRIDS      = 20;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_OBSTACLE;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    in_cell_char = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [SCORE_W-1:0]   out_square_size;
  logic [COL_W-1:0]     out_square_col;
  logic [ROW_W-1:0]     out_square_row;
  int                   failures;
  int                   pending_results;

  int burst_left   = 0;
  int random_cells = 0;
  int random_grids = 0;

  largest_empty_square_finder_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_char    (in_cell_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_square_size (out_square_size),
    .out_square_col  (out_square_col),
    .out_square_row  (out_square_row)
  );

  largest_empty_square_finder_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_char    (in_cell_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_square_size (out_square_size),
    .out_square_col  (out_square_col),
    .out_square_row  (out_square_row),
    .failures        (failures),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver switches between stall patterns, holding each one for a random span.
  initial begin : stall_pattern
    stall_mode_t mode;
    int          span;
    forever begin
      mode = stall_mode_t'($urandom_range(3));
      span = int'($urandom_range(300, 20));
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_HALF:     out_stall <= ($urandom_range(1) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(9) != 0);
          STALL_PERIODIC: out_stall <= ((k % 7) < 3);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // Offers one cell; bursts of requests are separated by random gaps.
  task automatic send_cell(input logic [CHAR_W-1:0] ch);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = int'($urandom_range(40, 1));
    end
    in_valid     <= 1'b1;
    in_cell_char <= ch;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Holds off new requests until every predicted result has been accepted.
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic load_config(input logic [CHAR_W-1:0] obstacle,
                             input logic [LEN_W-1:0]  length,
                             input logic [LEN_W-1:0]  count);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OBSTACLE;
    cfg_data  <= CFG_W'(obstacle);
    @(posedge clk);
    cfg_index <= CFG_ROW_LENGTH;
    cfg_data  <= length;
    @(posedge clk);
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int grid_dim(input logic [LEN_W-1:0] v);
    return (v == 0) ? 1 : (v > MAX_COLS) ? MAX_COLS : int'(v);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_cell(input logic [CHAR_W-1:0] obstacle,
                                                  input int blocked_pct);
    logic [CHAR_W-1:0] ch;
    if ($urandom_range(99) < blocked_pct) begin
      ch = obstacle;
    end else begin
      ch = CHAR_W'($urandom_range(255));
      if (ch == obstacle) ch = ch + 8'd1;
    end
    return ch;
  endfunction

  initial begin : stimulus
    logic [CHAR_W-1:0] obstacle;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  count;
    int                cells;
    int                blocked_pct;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one-cell grids with the obstacle byte 111.
    send_cell(8'd111);
    send_cell(8'd0);

    // A 3x3 grid with no obstacle yields a square covering all of it.
    load_config(8'hFF, 11'd3, 11'd3);
    send_cell(8'h00);
    send_cell(8'h80);
    send_cell(8'hFE);
    send_cell(8'h01);
    send_cell(8'h7F);
    send_cell(8'h55);
    send_cell(8'hAA);
    send_cell(8'h10);
    send_cell(8'h00);

    // Equal squares later in the grid must not replace the first.
    load_config(8'h00, 11'd4, 11'd1);
    send_cell(8'h41);
    send_cell(8'h00);
    send_cell(8'hFF);
    send_cell(8'h7E);

    // No empty cell at all.
    load_config(8'h2A, 11'd2, 11'd2);
    repeat (4) send_cell(8'h2A);

    // Zero lengths are treated as one.
    load_config(8'hFF, 11'd0, 11'd0);
    send_cell(8'hFF);

    while (random_cells < RANDOM_CELLS || random_grids < MIN_GRIDS) begin
      obstacle = CHAR_W'($urandom_range(255));
      case ($urandom_range(9))
        0:       length = 11'd0;
        1:       length = LEN_W'($urandom_range(16, 9));
        default: length = LEN_W'($urandom_range(6, 1));
      endcase
      case ($urandom_range(9))
        0:       count = 11'd0;
        1:       count = LEN_W'($urandom_range(16, 9));
        default: count = LEN_W'($urandom_range(6, 1));
      endcase
      load_config(obstacle, length, count);
      cells = grid_dim(length) * grid_dim(count);
      // One to four grids run back to back so the output register can back up.
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(19))
          0:       blocked_pct = 100;
          1, 2, 3: blocked_pct = 0;
          default: blocked_pct = int'($urandom_range(50));
        endcase
        for (int i = 0; i < cells; i++) begin
          send_cell(pick_cell(obstacle, blocked_pct));
        end
        random_cells += cells;
        random_grids++;
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
